@@ rtl/rrq_pkg.sv @@
package rrq_pkg;

  // Field widths of the request and response words.
  localparam int REQ_W    = 3;
  localparam int ID_W     = 22;
  localparam int STATE_W  = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PICK    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REQUEUE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd4;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  // Thread states that the scheduler searches for.
  localparam logic [STATE_W-1:0] TS_RUNNABLE = 2'd0;
  localparam logic [STATE_W-1:0] TS_RUNNING  = 2'd1;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [ID_W-1:0]    thread_id;
    logic [STATE_W-1:0] state_value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
    logic [STATE_W-1:0]  found_state;
    logic [COUNT_W-1:0]  entry_count;
  } out_word_t;

  // One queue entry as stored in memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STATE_W-1:0] state;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                accept;
    logic                scan_init;
    logic                scan_step;
    logic                shift_init;
    logic                shift_step;
    logic                add_write;
    logic                upd_write;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             full;
    logic             hit;
    logic             miss;
    logic             shift_end;
    logic             out_free;
  } dp_stat_t;

endpackage

@@ rtl/rrq_if.sv @@
interface rrq_in_if import rrq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrq_out_if import rrq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/round_robin_run_queue_unit.sv @@
// Round-robin run queue of thread entries, each an id and a state.
// Request channel (req): one word per request with req_type, thread_id and
// state_value. Codes are add, update state, pick next runnable, requeue
// running and lookup. Response channel (rsp): one word per request with
// status, found_id, found_state and entry_count.
// Both channels use valid/ready; a word moves when both are high.
// For pick and requeue, the search and the shift together walk every entry.
// A search that finds nothing also walks every entry.
// The memory read port is the limit: one entry read per cycle.
// One request is in work at a time. The next request is taken in the cycle
// after the response is loaded.
// The next request is taken even while the last response still waits in the
// output register. If the receiver stalls, the finished result waits and the
// block holds before loading the next response.
// Reset empties the queue at once; entry memory needs no clearing pass.
module round_robin_run_queue_unit import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  rrq_in_if.sink    req,
  rrq_out_if.source rsp
);

  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  logic      out_valid;
  out_word_t out_word;

  rrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrq_dpath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (req.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (rsp.ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

endmodule

@@ rtl/rrq_ram.sv @@
module rrq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rrq_ctrl.sv @@
module rrq_ctrl import rrq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;
  logic                res_found;
  logic                res_found_next;

  assign in_ready = (state == S_IDLE);

  // Sequencing of one request and the commands for each step.
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_found_next  = res_found;
    cmd             = '0;
    cmd.res_status  = res_status;
    cmd.res_found   = res_found;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept      = 1'b1;
          res_status_next = ST_OK;
          res_found_next  = 1'b0;
          state_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.req)
          REQ_ADD: begin
            if (stat.full) begin
              res_status_next = ST_FULL;
            end else begin
              cmd.add_write = 1'b1;
            end
            state_next = S_DONE;
          end
          REQ_UPDATE, REQ_PICK, REQ_REQUEUE, REQ_LOOKUP: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          if (stat.req == REQ_LOOKUP) begin
            res_found_next = 1'b1;
            state_next     = S_DONE;
          end else begin
            res_found_next = (stat.req == REQ_PICK);
            state_next     = S_ACT;
          end
        end else if (stat.miss) begin
          res_status_next = ST_NONE;
          state_next      = S_DONE;
        end
      end
      S_ACT: begin
        if (stat.req == REQ_UPDATE) begin
          cmd.upd_write = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_found  <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_found  <= res_found_next;
    end
  end

endmodule

@@ rtl/rrq_dpath.sv @@
module rrq_dpath import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  input  logic      out_ready,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [REQ_W-1:0]   req_r;
  logic [ID_W-1:0]    tid_r;
  logic [STATE_W-1:0] sv_r;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic               pend;
  logic [AW-1:0]      pend_idx;
  logic [AW-1:0]      pos;
  entry_t             held;
  entry_t             rd_data;
  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  logic [CW-1:0]      last_idx;
  logic               by_id;
  logic [STATE_W-1:0] key_state;
  logic               match;
  logic               more;

  rrq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  // Compare the word read last cycle against the search key.
  assign by_id     = (req_r == REQ_UPDATE) || (req_r == REQ_LOOKUP);
  assign key_state = (req_r == REQ_PICK) ? TS_RUNNABLE : TS_RUNNING;
  assign match     = by_id ? (rd_data.id == tid_r) : (rd_data.state == key_state);
  assign more      = (idx < count);
  assign last_idx  = count - CW'(1);

  assign stat.req       = req_r;
  assign stat.full      = (count >= CW'(QUEUE_DEPTH));
  assign stat.hit       = pend && match;
  assign stat.miss      = !pend && !more;
  assign stat.shift_end = !pend && !more;
  assign stat.out_free  = !out_valid || out_ready;

  // Memory write selection: append, state update, shift down, or the moved entry.
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = entry_t'{id: tid_r, state: sv_r};
    priority if (cmd.add_write) begin
      we = 1'b1;
    end else if (cmd.upd_write) begin
      we    = 1'b1;
      waddr = pos;
      wdata = entry_t'{id: held.id, state: sv_r};
    end else if (cmd.shift_step && pend) begin
      we    = 1'b1;
      waddr = pend_idx - AW'(1);
      wdata = rd_data;
    end else if (cmd.shift_step && !more) begin
      we    = 1'b1;
      waddr = last_idx[AW-1:0];
      wdata = held;
    end else begin
      we = 1'b0;
    end
  end

  // Request word capture and found entry.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_word.req_type;
      tid_r <= in_word.thread_id;
      sv_r  <= in_word.state_value;
    end
    if (cmd.scan_step && pend && match) begin
      held <= rd_data;
      pos  <= pend_idx;
    end
    if ((cmd.scan_step && !(pend && match) && more) || (cmd.shift_step && more)) begin
      pend_idx <= idx[AW-1:0];
    end
  end

  // Walk index, read pending flag and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      if (cmd.add_write) begin
        count <= count + CW'(1);
      end
      if (cmd.scan_init) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.shift_init) begin
        idx  <= CW'(pos) + CW'(1);
        pend <= 1'b0;
      end else if (cmd.scan_step && pend && match) begin
        pend <= 1'b0;
      end else if (cmd.scan_step || cmd.shift_step) begin
        if (more) begin
          pend <= 1'b1;
          idx  <= idx + CW'(1);
        end else begin
          pend <= 1'b0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_word.status      <= cmd.res_status;
      out_word.found_id    <= cmd.res_found ? held.id : '0;
      out_word.found_state <= cmd.res_found ? held.state : '0;
      out_word.entry_count <= COUNT_W'(count);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_add_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.add_write |-> !stat.full)
    else $error("append issued on a full queue");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    cmd.add_write |=> count == $past(count) + CW'(1))
    else $error("append did not grow the entry count");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken word");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    pend |-> (CW'(pend_idx) < count))
    else $error("memory walk read beyond the queue");
`endif

endmodule
